// ===== sv/cfp_pkg.sv =====
// Shared types and constants of the checksummed command frame parser.
package cfp_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
  localparam logic [7:0] ACK_FUNC_LO = 8'h10;
  localparam logic [7:0] ACK_FUNC_HI = 8'h15;

  localparam logic [7:0] ACK_BYTE0 = 8'hAA;
  localparam logic [7:0] ACK_BYTE1 = 8'hAA;
  localparam logic [7:0] ACK_BYTE2 = 8'hEF;
  localparam logic [7:0] ACK_BYTE3 = 8'h02;
  localparam logic [7:0] ACK_HDR_SUM = ACK_BYTE0 + ACK_BYTE1 + ACK_BYTE2 + ACK_BYTE3;

  localparam logic [8:0] LIMIT_RESET = 9'd50;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  localparam logic [2:0] ACK_LAST_STEP = 3'd7;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] func;
    logic       ok;
    logic       ack;
    logic [7:0] sum;
  } cmd_t;

endpackage

// ===== sv/cfp_in_if.sv =====
// Input byte channel of the frame parser.
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/cfp_out_if.sv =====
// Result channel of the frame parser.
interface cfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic [7:0] byte_index;
  logic [7:0] function_code;
  logic       checksum_ok;
  logic       last_of_item;

  modport source (output valid, output result_kind, output out_byte, output byte_index,
                  output function_code, output checksum_ok, output last_of_item,
                  input ready);
  modport sink (input valid, input result_kind, input out_byte, input byte_index,
                input function_code, input checksum_ok, input last_of_item,
                output ready);
endinterface

// ===== sv/cfp_front.sv =====
// Front end: frame recognizer that turns received bytes into commands.
module cfp_front (
  input  logic          clk,
  input  logic          rst_n,
  cfp_in_if.sink        in_ch,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_wdata,
  input  logic          q_full,
  output logic          push,
  output cfp_pkg::cmd_t push_cmd
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HDR     = 3'd1;
  localparam logic [2:0] PH_FUNC    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] func_r, func_nxt;
  logic [8:0] limit_r;
  logic       accept;
  logic [7:0] b;
  logic       ok;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.rx_byte;
  assign ok          = (sum_r == b);

  always_comb begin
    phase_nxt = phase_r;
    remain_nxt = remain_r;
    count_nxt = count_r;
    sum_nxt = sum_r;
    func_nxt = func_r;
    push = 1'b0;
    push_cmd.is_end = 1'b0;
    push_cmd.data = b;
    push_cmd.index = count_r;
    push_cmd.func = func_r;
    push_cmd.ok = 1'b0;
    push_cmd.ack = 1'b0;
    push_cmd.sum = sum_r;
    if (accept) begin
      priority if (phase_r == PH_IDLE && b == cfp_pkg::HDR_FIRST) begin
        phase_nxt = PH_HDR;
        sum_nxt = b;
      end else if (phase_r == PH_HDR && b == cfp_pkg::HDR_SECOND) begin
        phase_nxt = PH_FUNC;
        sum_nxt = sum_r + b;
      end else if (phase_r == PH_FUNC && b < cfp_pkg::FUNC_LIMIT) begin
        phase_nxt = PH_LEN;
        func_nxt = b;
        sum_nxt = sum_r + b;
      end else if (phase_r == PH_LEN && {1'b0, b} < limit_r) begin
        phase_nxt = PH_PAYLOAD;
        remain_nxt = b;
        count_nxt = 8'd0;
        sum_nxt = sum_r + b;
      end else if (phase_r == PH_PAYLOAD && remain_r != 8'd0) begin
        push = 1'b1;
        count_nxt = count_r + 8'd1;
        remain_nxt = remain_r - 8'd1;
        sum_nxt = sum_r + b;
        if (remain_r == 8'd1) begin
          phase_nxt = PH_CHECK;
        end
      end else if (phase_r == PH_CHECK) begin
        phase_nxt = PH_IDLE;
        push = 1'b1;
        push_cmd.is_end = 1'b1;
        push_cmd.index = 8'd0;
        push_cmd.ok = ok;
        push_cmd.ack = ok && func_r >= cfp_pkg::ACK_FUNC_LO && func_r <= cfp_pkg::ACK_FUNC_HI;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      remain_r <= 8'd0;
      count_r <= 8'd0;
      sum_r <= 8'd0;
      func_r <= 8'd0;
      limit_r <= cfp_pkg::LIMIT_RESET;
    end else begin
      phase_r <= phase_nxt;
      remain_r <= remain_nxt;
      count_r <= count_nxt;
      sum_r <= sum_nxt;
      func_r <= func_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

endmodule

// ===== sv/cfp_queue.sv =====
// Command queue between the frame recognizer and the result sequencer.
module cfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output cfp_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cfp_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/cfp_back.sv =====
// Back end: expands commands into result items behind an output register.
module cfp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cfp_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  cfp_out_if.source     out_ch
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [7:0] index_r, index_nxt;
  logic [7:0] func_r;
  logic       ok_r, ok_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       fire;
  logic       done;
  logic [2:0] ack_idx;
  logic [7:0] ack_byte;

  assign load    = !out_valid_r || out_ch.ready;
  assign fire    = load && !q_empty;
  assign pop     = fire && done;
  assign ack_idx = step_r - 3'd1;

  always_comb begin
    unique case (ack_idx)
      3'd0:    ack_byte = cfp_pkg::ACK_BYTE0;
      3'd1:    ack_byte = cfp_pkg::ACK_BYTE1;
      3'd2:    ack_byte = cfp_pkg::ACK_BYTE2;
      3'd3:    ack_byte = cfp_pkg::ACK_BYTE3;
      3'd4:    ack_byte = head.func;
      3'd5:    ack_byte = head.sum;
      default: ack_byte = cfp_pkg::ACK_HDR_SUM + head.func + head.sum;
    endcase
  end

  always_comb begin
    kind_nxt = cfp_pkg::KIND_PAYLOAD;
    byte_nxt = head.data;
    index_nxt = head.index;
    ok_nxt = 1'b0;
    last_nxt = 1'b1;
    done = 1'b1;
    if (head.is_end) begin
      if (step_r == 3'd0) begin
        kind_nxt = cfp_pkg::KIND_END;
        index_nxt = 8'd0;
        ok_nxt = head.ok;
        last_nxt = !head.ack;
        done = !head.ack;
      end else begin
        kind_nxt = cfp_pkg::KIND_ACK;
        byte_nxt = ack_byte;
        index_nxt = {5'd0, ack_idx};
        last_nxt = (step_r == cfp_pkg::ACK_LAST_STEP);
        done = (step_r == cfp_pkg::ACK_LAST_STEP);
      end
    end
    step_nxt = done ? 3'd0 : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      if (load) begin
        out_valid_r <= !q_empty;
      end
      if (fire) begin
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      index_r <= index_nxt;
      func_r <= head.func;
      ok_r <= ok_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = kind_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.byte_index    = index_r;
  assign out_ch.function_code = func_r;
  assign out_ch.checksum_ok   = ok_r;
  assign out_ch.last_of_item  = last_r;

endmodule

// ===== sv/checksummed_command_frame_parser_core.sv =====
// Top level of the checksummed command frame parser.
//
// in_ch carries one received byte per item; out_ch carries result items:
// payload bytes with their index, one frame-end status per checksum byte,
// and for accepted commands 0x10 to 0x15 seven acknowledge bytes after it.
// last_of_item marks the final result caused by one input byte. The user
// writes the length limit (reset value 50) via cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this.
// A byte's command is queued before its first result is registered at the
// output. Throughput: one input byte per cycle while the result side keeps
// up; the single output register emits one result per ready cycle, so a
// checksum byte that triggers an acknowledge occupies the output for eight
// results. The command queue (QUEUE_DEPTH entries) absorbs that burst; when
// it fills, in_ch.ready drops until the output drains.
//
// Reset (rst_n low at a clock edge) returns the parser to waiting for a
// header, empties the queue and clears the output. A stalled receiver holds
// the current result; bytes keep being accepted until the queue is full.
module checksummed_command_frame_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  cfp_in_if.sink     in_ch,
  cfp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  cfp_pkg::cmd_t q_push_cmd;
  cfp_pkg::cmd_t q_head;

  cfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  cfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  cfp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_empty(q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_ack_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind == cfp_pkg::KIND_ACK && out_ch.byte_index == 8'd6)
      |-> out_ch.last_of_item)
    else $error("final acknowledge byte not marked last");

  a_payload_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind == cfp_pkg::KIND_PAYLOAD) |-> out_ch.last_of_item)
    else $error("payload result not marked last");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the checksummed command frame parser core.
module tb_top;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] func;
    logic       ok;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {CHK_NONE, CHK_ONE, CHK_PREDICT} row_check_t;

  typedef struct packed {
    logic [7:0] rx;
    row_check_t how;
    result_t    want;
  } row_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_GOT_AA, PH_GOT_AF, PH_GOT_FUNC, PH_PAYLOAD, PH_CHECKSUM
  } parse_phase_t;

  localparam result_t NO_RESULT = '0;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam row_t DIRECTED_ROWS [25] = '{
    '{cfp_pkg::HDR_FIRST, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_SECOND, CHK_NONE, NO_RESULT},
    '{8'h10, CHK_NONE, NO_RESULT},
    '{8'h02, CHK_NONE, NO_RESULT},
    '{8'h00, CHK_ONE, '{cfp_pkg::KIND_PAYLOAD, 8'h00, 8'd0, 8'h10, 1'b0, 1'b1}},
    '{8'hFF, CHK_ONE, '{cfp_pkg::KIND_PAYLOAD, 8'hFF, 8'd1, 8'h10, 1'b0, 1'b1}},
    '{8'h6A, CHK_PREDICT, NO_RESULT},
    '{cfp_pkg::HDR_FIRST, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_SECOND, CHK_NONE, NO_RESULT},
    '{8'hF0, CHK_NONE, NO_RESULT},
    '{8'h01, CHK_NONE, NO_RESULT},
    '{8'h55, CHK_ONE, '{cfp_pkg::KIND_PAYLOAD, 8'h55, 8'd0, 8'hF0, 1'b0, 1'b1}},
    '{8'h00, CHK_ONE, '{cfp_pkg::KIND_END, 8'h00, 8'd0, 8'hF0, 1'b0, 1'b1}},
    '{cfp_pkg::HDR_FIRST, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_SECOND, CHK_NONE, NO_RESULT},
    '{8'hF1, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_FIRST, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_SECOND, CHK_NONE, NO_RESULT},
    '{8'h00, CHK_NONE, NO_RESULT},
    '{8'h32, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_FIRST, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_SECOND, CHK_NONE, NO_RESULT},
    '{8'h15, CHK_NONE, NO_RESULT},
    '{8'h00, CHK_NONE, NO_RESULT},
    '{cfp_pkg::HDR_FIRST, CHK_NONE, NO_RESULT}
  };

  localparam logic [8:0] LIMIT_STEPS [6] = '{9'd256, 9'd1, 9'd8, 9'd50, 9'd17, 9'd3};

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [8:0] cfg_wdata;

  cfp_in_if  in_ch ();
  cfp_out_if out_ch ();

  checksummed_command_frame_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  parse_phase_t phase;
  logic [7:0]   remaining;
  logic [7:0]   pay_count;
  logic [7:0]   run_sum;
  logic [7:0]   cur_func;
  logic [8:0]   limit_cfg;

  result_t outputs_due [$];
  int      fault_count;
  int      items_sent;
  int      send_calm;
  int      idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b, output result_t res [$]);
    logic [7:0] ack [7];
    logic [7:0] ack_sum;
    res = {};
    if (phase == PH_IDLE && b == cfp_pkg::HDR_FIRST) begin
      phase = PH_GOT_AA;
      run_sum = b;
    end else if (phase == PH_GOT_AA && b == cfp_pkg::HDR_SECOND) begin
      phase = PH_GOT_AF;
      run_sum += b;
    end else if (phase == PH_GOT_AF && b < cfp_pkg::FUNC_LIMIT) begin
      phase = PH_GOT_FUNC;
      cur_func = b;
      run_sum += b;
    end else if (phase == PH_GOT_FUNC && {1'b0, b} < limit_cfg) begin
      phase = PH_PAYLOAD;
      remaining = b;
      pay_count = 8'd0;
      run_sum += b;
    end else if (phase == PH_PAYLOAD && remaining != 8'd0) begin
      res.push_back({cfp_pkg::KIND_PAYLOAD, b, pay_count, cur_func, 1'b0, 1'b0});
      pay_count++;
      remaining--;
      run_sum += b;
      if (remaining == 8'd0) phase = PH_CHECKSUM;
    end else if (phase == PH_CHECKSUM) begin
      phase = PH_IDLE;
      res.push_back({cfp_pkg::KIND_END, b, 8'd0, cur_func, run_sum == b, 1'b0});
      if (run_sum == b && cur_func >= cfp_pkg::ACK_FUNC_LO &&
          cur_func <= cfp_pkg::ACK_FUNC_HI) begin
        ack = '{cfp_pkg::ACK_BYTE0, cfp_pkg::ACK_BYTE1, cfp_pkg::ACK_BYTE2,
                cfp_pkg::ACK_BYTE3, cur_func, run_sum, 8'h00};
        ack_sum = 8'd0;
        for (int i = 0; i < 6; i++) ack_sum += ack[i];
        ack[6] = ack_sum;
        for (int i = 0; i < 7; i++)
          res.push_back({cfp_pkg::KIND_ACK, ack[i], 8'(i), cur_func, 1'b0, 1'b0});
      end
    end else begin
      phase = PH_IDLE;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] b, input row_check_t how = CHK_PREDICT,
                           input result_t want = NO_RESULT);
    int      gap;
    result_t res [$];
    gap = draw_wait(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    parse_rx_byte(b, res);
    case (how)
      CHK_NONE: ;
      CHK_ONE: outputs_due.push_back(want);
      default: foreach (res[i]) outputs_due.push_back(res[i]);
    endcase
  endtask

  task automatic send_frame(input int forced_len);
    logic [7:0] frame_bytes [$];
    logic [7:0] func;
    logic [7:0] len;
    logic [7:0] sum;
    int         cap;
    int         pick;
    int         keep;
    cap = int'(limit_cfg) - 1;
    if (cap > 255) cap = 255;
    pick = $urandom_range(0, 9);
    if (pick < 5) func = cfp_pkg::ACK_FUNC_LO + 8'($urandom_range(0, 5));
    else if (pick < 9) func = 8'($urandom_range(0, 240));
    else func = 8'($urandom_range(241, 255));
    pick = $urandom_range(0, 9);
    if (forced_len >= 0) len = 8'(forced_len);
    else if (pick == 0 && limit_cfg <= 9'd255) len = limit_cfg[7:0];
    else if (pick == 1 && cap <= 16) len = 8'(cap);
    else len = 8'($urandom_range(0, cap < 6 ? cap : 6));
    frame_bytes = '{cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, func, len};
    if ($urandom_range(0, 19) == 0) frame_bytes[1] = 8'($urandom);
    repeat (len) frame_bytes.push_back(8'($urandom));
    sum = 8'd0;
    foreach (frame_bytes[i]) sum += frame_bytes[i];
    frame_bytes.push_back($urandom_range(0, 6) == 0 ? 8'($urandom) : sum);
    keep = frame_bytes.size();
    if ($urandom_range(0, 9) == 0) keep = $urandom_range(1, keep - 1);
    for (int i = 0; i < keep; i++) push_byte(frame_bytes[i]);
  endtask

  task automatic write_length_limit(input logic [8:0] value);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    limit_cfg = value;
  endtask

  function automatic void note_fault(input string what, input result_t want, input result_t got);
    fault_count++;
    if (fault_count <= 10)
      $display({"%s: expected kind %0d byte %02h index %0d func %02h ok %0b last %0b,",
                " got kind %0d byte %02h index %0d func %02h ok %0b last %0b"},
               what, want.kind, want.data, want.index, want.func, want.ok, want.last,
               got.kind, got.data, got.index, got.func, got.ok, got.last);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.result_kind, out_ch.out_byte, out_ch.byte_index, out_ch.function_code,
             out_ch.checksum_ok, out_ch.last_of_item};
      if (outputs_due.size() == 0) begin
        note_fault("unexpected result", NO_RESULT, got);
      end else begin
        want = outputs_due.pop_front();
        if (got !== want) note_fault("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    int calm;
    calm = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = draw_wait(calm);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int phase_stop;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    phase = PH_IDLE;
    remaining = '0;
    pay_count = '0;
    run_sum = '0;
    cur_func = '0;
    limit_cfg = cfp_pkg::LIMIT_RESET;
    fault_count = 0;
    items_sent = 0;
    send_calm = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED_ROWS[r]) push_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].how,
                                         DIRECTED_ROWS[r].want);

    foreach (LIMIT_STEPS[p]) begin
      write_length_limit(LIMIT_STEPS[p]);
      if (LIMIT_STEPS[p] == 9'd256) send_frame(255);
      phase_stop = items_sent + 10;
      while (items_sent < phase_stop) begin
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        else send_frame(-1);
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== checksummed_command_frame_parser_core.f =====
sv/cfp_pkg.sv
sv/cfp_in_if.sv
sv/cfp_out_if.sv
sv/cfp_front.sv
sv/cfp_queue.sv
sv/cfp_back.sv
sv/checksummed_command_frame_parser_core.sv
bench/tb_top.sv
